// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- sv/ppwm_pkg.sv -----
package ppwm_pkg;

    localparam int unsigned PERIOD_W = 30;
    localparam int unsigned DIV_W    = 16;
    localparam int unsigned PROD_W   = PERIOD_W + DIV_W;
    localparam int unsigned CNT_W    = 6;

    localparam logic [PERIOD_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [CNT_W-1:0] PERIOD_STEPS = 6'(PERIOD_W - 1);
    localparam logic [CNT_W-1:0] DUTY_STEPS   = 6'(PROD_W - 1);

    typedef enum logic [1:0] {
        ST_IGNORED   = 2'd0,
        ST_UNCHANGED = 2'd1,
        ST_APPLIED   = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PERIOD = 5'b00010,
        S_MUL    = 5'b00100,
        S_DUTY   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

// ----- sv/packet_to_pwm_setting.sv -----
// PWM command word to PWM setting.
// Input channel: in_valid / in_stall with the packet fields as separate ports.
// Output channel: out_valid / out_stall with status, seq_gap, period_ns,
// duty_ns and enabled. A word moves at an edge with valid high and stall low.
// own_channel is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while idle, which the block does not enforce. Ignored, unchanged and
// invalid words give their result in the cycle after accept. An applied word
// runs one shared restoring divider, one quotient bit per cycle: first 1e9 /
// freq for the period, then period * value, then the product / scale for the
// duty. One word is in flight at a time: in_stall is high from accept until
// the result is taken.
// While out_stall is high the result holds and no new word is taken.
// Reset clears the stored settings, own_channel and all control state; the
// block comes out of reset idle with no result pending.
`include "assert_macros.svh"

module packet_to_pwm_setting (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        not_for_us,
    input  logic [7:0]  channel,
    input  logic [31:0] seq,
    input  logic [7:0]  enable,
    input  logic [15:0] value,
    input  logic [15:0] scale,
    input  logic [15:0] offset,
    input  logic [15:0] freq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        seq_gap,
    output logic [29:0] period_ns,
    output logic [29:0] duty_ns,
    output logic        enabled
);

    localparam int unsigned PW = ppwm_pkg::PERIOD_W;
    localparam int unsigned DW = ppwm_pkg::DIV_W;
    localparam int unsigned QW = ppwm_pkg::PROD_W;
    localparam int unsigned CW = ppwm_pkg::CNT_W;

    ppwm_pkg::state_t state_reg, state_next;
    logic [7:0]    own_channel_reg;
    logic          started_reg, started_next;
    logic [31:0]   last_seq_reg, last_seq_next;
    logic [7:0]    last_enable_reg, last_enable_next;
    logic [15:0]   last_freq_reg, last_freq_next;
    logic [15:0]   last_scale_reg, last_scale_next;
    logic [15:0]   last_offset_reg, last_offset_next;
    logic [15:0]   last_value_reg, last_value_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [1:0]    status_reg, status_next;
    logic          gap_reg, gap_next;
    logic [PW-1:0] period_reg, period_next;
    logic [PW-1:0] duty_reg, duty_next;
    logic          enabled_reg, enabled_next;

    logic          accept;
    logic          hit;
    logic          gap;
    logic          differs;
    logic [DW-1:0] divisor;
    logic [DW:0]   shifted;
    logic [DW-1:0] diff;
    logic          ge;
    logic [DW-1:0] step_rem;
    logic [QW-1:0] step_q;
    logic [QW-1:0] product;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ppwm_pkg::S_IDLE);
    assign out_valid = (state_reg == ppwm_pkg::S_DONE);

    assign hit     = !not_for_us && (channel == own_channel_reg);
    assign gap     = started_reg && ((last_seq_reg + 32'd1) != seq);
    assign differs = (enable != last_enable_reg) || (freq != last_freq_reg) ||
                     (scale != last_scale_reg) || (offset != last_offset_reg) ||
                     (value != last_value_reg);

    assign divisor  = (state_reg == ppwm_pkg::S_PERIOD) ? last_freq_reg : last_scale_reg;
    assign shifted  = {rem_reg, q_reg[QW-1]};
    assign diff     = shifted[DW-1:0] - divisor;
    assign ge       = (shifted >= {1'b0, divisor});
    assign step_rem = ge ? diff : shifted[DW-1:0];
    assign step_q   = {q_reg[QW-2:0], ge};
    assign product  = {{DW{1'b0}}, period_reg} * {{PW{1'b0}}, last_value_reg};

    always_comb
    begin
        state_next       = state_reg;
        started_next     = started_reg;
        last_seq_next    = last_seq_reg;
        last_enable_next = last_enable_reg;
        last_freq_next   = last_freq_reg;
        last_scale_next  = last_scale_reg;
        last_offset_next = last_offset_reg;
        last_value_next  = last_value_reg;
        cnt_next         = cnt_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        status_next      = status_reg;
        gap_next         = gap_reg;
        period_next      = period_reg;
        duty_next        = duty_reg;
        enabled_next     = enabled_reg;

        case (state_reg)
            ppwm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    gap_next     = 1'b0;
                    period_next  = '0;
                    duty_next    = '0;
                    enabled_next = 1'b0;
                    state_next   = ppwm_pkg::S_DONE;
                    if (!hit)
                    begin
                        status_next = ppwm_pkg::ST_IGNORED;
                    end
                    else if (started_reg && !differs)
                    begin
                        status_next = ppwm_pkg::ST_UNCHANGED;
                        gap_next    = gap;
                    end
                    else if (freq == 16'd0 || scale == 16'd0)
                    begin
                        status_next = ppwm_pkg::ST_INVALID;
                        gap_next    = gap;
                    end
                    else
                    begin
                        status_next      = ppwm_pkg::ST_APPLIED;
                        gap_next         = gap;
                        enabled_next     = (enable != 8'd0);
                        started_next     = 1'b1;
                        last_seq_next    = seq;
                        last_enable_next = enable;
                        last_freq_next   = freq;
                        last_scale_next  = scale;
                        last_offset_next = offset;
                        last_value_next  = value;
                        q_next           = {ppwm_pkg::NS_PER_SEC, {DW{1'b0}}};
                        rem_next         = '0;
                        cnt_next         = ppwm_pkg::PERIOD_STEPS;
                        state_next       = ppwm_pkg::S_PERIOD;
                    end
                end
            end
            ppwm_pkg::S_PERIOD:
            begin
                q_next   = step_q;
                rem_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    period_next = step_q[PW-1:0];
                    state_next  = ppwm_pkg::S_MUL;
                end
            end
            ppwm_pkg::S_MUL:
            begin
                q_next     = product;
                rem_next   = '0;
                cnt_next   = ppwm_pkg::DUTY_STEPS;
                state_next = ppwm_pkg::S_DUTY;
            end
            ppwm_pkg::S_DUTY:
            begin
                q_next   = step_q;
                rem_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    duty_next  = (step_q > {{DW{1'b0}}, period_reg}) ? period_reg
                                                                     : step_q[PW-1:0];
                    state_next = ppwm_pkg::S_DONE;
                end
            end
            ppwm_pkg::S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ppwm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppwm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ppwm_pkg::S_IDLE;
            own_channel_reg <= '0;
            started_reg     <= 1'b0;
            last_seq_reg    <= '0;
            last_enable_reg <= '0;
            last_freq_reg   <= '0;
            last_scale_reg  <= '0;
            last_offset_reg <= '0;
            last_value_reg  <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wr_en)
            begin
                own_channel_reg <= cfg_wr_data;
            end
            started_reg     <= started_next;
            last_seq_reg    <= last_seq_next;
            last_enable_reg <= last_enable_next;
            last_freq_reg   <= last_freq_next;
            last_scale_reg  <= last_scale_next;
            last_offset_reg <= last_offset_next;
            last_value_reg  <= last_value_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
        gap_reg     <= gap_next;
        period_reg  <= period_next;
        duty_reg    <= duty_next;
        enabled_reg <= enabled_next;
    end

    assign status    = status_reg;
    assign seq_gap   = gap_reg;
    assign period_ns = period_reg;
    assign duty_ns   = duty_reg;
    assign enabled   = enabled_reg;

    `ASSERT_CLK(a_one_in_flight, out_valid |-> in_stall, "result pending while taking a word")
    `ASSERT_CLK(a_duty_clamped,
        out_valid && status == ppwm_pkg::ST_APPLIED |-> duty_ns <= period_ns,
        "duty exceeds period")
    `ASSERT_NEVER(a_quiet_payload,
        out_valid && status != ppwm_pkg::ST_APPLIED &&
        (period_ns != '0 || duty_ns != '0 || enabled),
        "payload set on unapplied result")
    `ASSERT_CLK(a_ignored_no_gap,
        out_valid && status == ppwm_pkg::ST_IGNORED |-> !seq_gap,
        "gap flagged on ignored word")

endmodule
